[design/mcst_pkg.sv]
// Shared constants, codes and types for the multi-channel software timer unit.
package mcst_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int IDX_W      = 4;
    localparam int ACTION_W   = 3;
    localparam int KIND_W     = 2;
    localparam int PERIOD_W   = 24;
    localparam int TIME_W     = 32;
    localparam int ENTRY_W    = PERIOD_W + TIME_W;

    localparam logic [TIME_W-1:0] SIGN_FLIP = {1'b1, {(TIME_W-1){1'b0}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_CREATE     = 3'd1,
        ACT_START      = 3'd2,
        ACT_STOP       = 3'd3,
        ACT_SET_PERIOD = 3'd4
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CMD       = 2'd0,
        KIND_FIRED     = 2'd1,
        KIND_IDLE_TICK = 2'd2
    } kind_t;

    typedef struct packed {
        logic clr;
        logic ins;
        logic pop;
    } fl_ctrl_t;

    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] key;
        logic [SLOT_W-1:0] idx;
    } fl_cell_t;

    typedef struct packed {
        logic              head_vld;
        logic [SLOT_W-1:0] head_idx;
        logic              next_vld;
    } fl_stat_t;

endpackage

[design/mcst_ram.sv]
// Simple dual-port timer slot memory with one write and one registered read port.
module mcst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 56
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/mcst_fire_list.sv]
// Sorted list of due timers, filled by insertion during a scan and drained from the head.
module mcst_fire_list (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mcst_pkg::fl_ctrl_t             ctrl,
    input  logic [mcst_pkg::TIME_W-1:0]    ins_key,
    input  logic [mcst_pkg::SLOT_W-1:0]    ins_idx,
    output mcst_pkg::fl_stat_t             stat
);

    localparam int N = mcst_pkg::NUM_TIMERS;

    mcst_pkg::fl_cell_t cells_reg  [N];
    mcst_pkg::fl_cell_t cells_next [N];
    mcst_pkg::fl_cell_t new_cell;
    mcst_pkg::fl_cell_t empty_cell;
    logic [N-1:0]       ins_pos;

    assign new_cell   = '{vld: 1'b1, key: ins_key, idx: ins_idx};
    assign empty_cell = '{vld: 1'b0, key: '0, idx: '0};

    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_cell
            assign ins_pos[j] = !cells_reg[j].vld || (cells_reg[j].key > ins_key);

            always_comb begin
                cells_next[j] = cells_reg[j];
                if (ctrl.clr) begin
                    cells_next[j] = empty_cell;
                end else if (ctrl.ins) begin
                    if (ins_pos[j]) begin
                        if (j == 0) begin
                            cells_next[j] = new_cell;
                        end else if (!ins_pos[(j > 0) ? j - 1 : 0]) begin
                            cells_next[j] = new_cell;
                        end else begin
                            cells_next[j] = cells_reg[(j > 0) ? j - 1 : 0];
                        end
                    end
                end else if (ctrl.pop) begin
                    if (j == N - 1) begin
                        cells_next[j] = empty_cell;
                    end else begin
                        cells_next[j] = cells_reg[(j < N - 1) ? j + 1 : j];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cells_reg[j].vld <= 1'b0;
                end else begin
                    cells_reg[j] <= cells_next[j];
                end
            end
        end
    endgenerate

    assign stat.head_vld = cells_reg[0].vld;
    assign stat.head_idx = cells_reg[0].idx;
    assign stat.next_vld = (N > 1) ? cells_reg[(N > 1) ? 1 : 0].vld : 1'b0;

endmodule

[design/multi_channel_software_timer_unit.sv]
// Top level of the multi-channel software timer unit: command decode, tick scan and result output.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_action, s_timer_index, s_period, s_repeat_req
//   m_      | out       | m_valid / m_ready  | m_kind, m_fired_index, m_status, m_last
//
// Create, stop, set period and unused codes are answered directly; start first reads the period from the
// slot memory, then writes the deadline. A tick sweeps the slot memory through its single read port,
// then emits its results.
// Reset clears time and all slot flags at once; the slot memory needs no clearing pass.
// m_ready low holds the current result; s_ready is high only when idle with the output free.
module multi_channel_software_timer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mcst_pkg::ACTION_W-1:0]     s_action,
    input  logic [mcst_pkg::IDX_W-1:0]        s_timer_index,
    input  logic [mcst_pkg::PERIOD_W-1:0]     s_period,
    input  logic                              s_repeat_req,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mcst_pkg::KIND_W-1:0]       m_kind,
    output logic [mcst_pkg::IDX_W-1:0]        m_fired_index,
    output logic                              m_status,
    output logic                              m_last
);

    localparam int N       = mcst_pkg::NUM_TIMERS;
    localparam int SLOT_W  = mcst_pkg::SLOT_W;
    localparam int TIME_W  = mcst_pkg::TIME_W;
    localparam int ENTRY_W = mcst_pkg::ENTRY_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_START = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [TIME_W-1:0]            time_reg, time_next;
    logic [N-1:0]                 created_reg, created_next;
    logic [N-1:0]                 active_reg, active_next;
    logic [N-1:0]                 repeat_reg, repeat_next;
    logic [SLOT_W-1:0]            cnt_reg, cnt_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;

    logic                         m_valid_reg, m_valid_next;
    logic [mcst_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [mcst_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                         status_reg, status_next;
    logic                         last_reg, last_next;

    logic                         wr_en, rd_en;
    logic [SLOT_W-1:0]            wr_addr, rd_addr;
    logic [ENTRY_W-1:0]           wr_data, rd_data;
    logic [mcst_pkg::PERIOD_W-1:0] rd_period;
    logic [TIME_W-1:0]            rd_deadline;
    logic [TIME_W-1:0]            diff;
    logic                         due;

    mcst_pkg::fl_ctrl_t           fl_ctrl;
    mcst_pkg::fl_stat_t           fl_stat;
    logic [TIME_W-1:0]            ins_key;
    logic [SLOT_W-1:0]            ins_idx;

    logic                         out_free;
    logic                         in_range;
    logic [SLOT_W-1:0]            in_slot;
    logic                         made;

    mcst_ram #(
        .DEPTH (N),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mcst_fire_list u_fire_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fl_ctrl),
        .ins_key (ins_key),
        .ins_idx (ins_idx),
        .stat    (fl_stat)
    );

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_IDLE) && out_free;
    assign in_range    = 32'(s_timer_index) < N;
    assign in_slot     = SLOT_W'(s_timer_index);
    assign made        = in_range && created_reg[in_slot];
    assign rd_period   = rd_data[ENTRY_W-1:TIME_W];
    assign rd_deadline = rd_data[TIME_W-1:0];
    assign diff        = rd_deadline - time_reg;
    assign due         = active_reg[cnt_reg] && ((diff == '0) || diff[TIME_W-1]);
    assign ins_key     = diff ^ mcst_pkg::SIGN_FLIP;
    assign ins_idx     = cnt_reg;

    always_comb begin
        state_next   = state_reg;
        time_next    = time_reg;
        created_next = created_reg;
        active_next  = active_reg;
        repeat_next  = repeat_reg;
        cnt_next     = cnt_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        fl_ctrl      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_action == mcst_pkg::ACT_TICK) begin
                        time_next   = time_reg + 1'b1;
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        cnt_next    = '0;
                        fl_ctrl.clr = 1'b1;
                        state_next  = ST_SCAN;
                    end else begin
                        m_valid_next = 1'b1;
                        kind_next    = mcst_pkg::KIND_CMD;
                        idx_next     = s_timer_index;
                        last_next    = 1'b1;
                        status_next  = 1'b0;
                        case (s_action)
                            mcst_pkg::ACT_CREATE: begin
                                status_next = !in_range;
                                if (in_range) begin
                                    created_next[in_slot] = 1'b1;
                                    repeat_next[in_slot]  = s_repeat_req;
                                    active_next[in_slot]  = 1'b0;
                                    wr_en   = 1'b1;
                                    wr_addr = in_slot;
                                    wr_data = {s_period, {TIME_W{1'b0}}};
                                end
                            end
                            mcst_pkg::ACT_START: begin
                                status_next = !made;
                                if (made) begin
                                    rd_en      = 1'b1;
                                    rd_addr    = in_slot;
                                    slot_next  = in_slot;
                                    state_next = ST_START;
                                end
                            end
                            mcst_pkg::ACT_STOP: begin
                                status_next = !made;
                                if (made) begin
                                    active_next[in_slot] = 1'b0;
                                end
                            end
                            mcst_pkg::ACT_SET_PERIOD: begin
                                status_next = !made;
                                if (made) begin
                                    active_next[in_slot] = 1'b1;
                                    wr_en   = 1'b1;
                                    wr_addr = in_slot;
                                    wr_data = {s_period, time_reg + TIME_W'(s_period)};
                                end
                            end
                            default: begin
                                status_next = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_SCAN: begin
                if (due) begin
                    fl_ctrl.ins = 1'b1;
                    if (repeat_reg[cnt_reg]) begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_reg;
                        wr_data = {rd_period, rd_deadline + TIME_W'(rd_period)};
                    end else begin
                        active_next[cnt_reg] = 1'b0;
                    end
                end
                if (32'(cnt_reg) == N - 1) begin
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = cnt_reg + 1'b1;
                end
            end
            ST_START: begin
                wr_en                 = 1'b1;
                wr_addr               = slot_reg;
                wr_data               = {rd_period, time_reg + TIME_W'(rd_period)};
                active_next[slot_reg] = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    status_next  = 1'b0;
                    if (fl_stat.head_vld) begin
                        kind_next   = mcst_pkg::KIND_FIRED;
                        idx_next    = mcst_pkg::IDX_W'(fl_stat.head_idx);
                        last_next   = !fl_stat.next_vld;
                        fl_ctrl.pop = 1'b1;
                        if (!fl_stat.next_vld) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        kind_next  = mcst_pkg::KIND_IDLE_TICK;
                        idx_next   = '0;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            created_reg <= '0;
            active_reg  <= '0;
            repeat_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            time_reg    <= time_next;
            created_reg <= created_next;
            active_reg  <= active_next;
            repeat_reg  <= repeat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        slot_reg   <= slot_next;
        kind_reg   <= kind_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_fired_index = idx_reg;
    assign m_status      = status_reg;
    assign m_last        = last_reg;

endmodule

[design/mcst_checker.sv]
// Port-level checks for the multi-channel software timer unit, bound to the top level.
module mcst_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [mcst_pkg::ACTION_W-1:0]     s_action,
    input logic [mcst_pkg::IDX_W-1:0]        s_timer_index,
    input logic [mcst_pkg::PERIOD_W-1:0]     s_period,
    input logic                              s_repeat_req,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [mcst_pkg::KIND_W-1:0]       m_kind,
    input logic [mcst_pkg::IDX_W-1:0]        m_fired_index,
    input logic                              m_status,
    input logic                              m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_fired_index)
            && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    a_cmd_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action != mcst_pkg::ACT_TICK)
            |=> m_valid && (m_kind == mcst_pkg::KIND_CMD) && m_last
            && (m_fired_index == $past(s_timer_index)))
        else $error("command request not answered next cycle");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == mcst_pkg::KIND_IDLE_TICK)
            |-> m_last && (m_fired_index == '0) && !m_status)
        else $error("empty tick result malformed");

    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == mcst_pkg::KIND_FIRED) |-> !m_status && (m_last || !s_ready))
        else $error("fired result with status or with input open");

endmodule

bind multi_channel_software_timer_unit mcst_checker u_mcst_checker (.*);

[bench/multi_channel_software_timer_unit_tb.sv]
// Self-checking testbench for the multi-channel software timer unit: directed table plus random traffic.
module multi_channel_software_timer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mcst_pkg::ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [mcst_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int MAX_FIRES   = 16;
    localparam int RANDOM_REQS = 195;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PLAN_LEN    = 25;

    typedef struct packed {
        mcst_pkg::kind_t             kind;
        logic [mcst_pkg::IDX_W-1:0]  slot;
        logic                        status;
        logic                        last;
    } reply_t;

    typedef struct packed {
        logic [mcst_pkg::ACTION_W-1:0] act;
        logic [mcst_pkg::IDX_W-1:0]    slot;
        logic [mcst_pkg::PERIOD_W-1:0] per;
        logic                          rep;
        logic                          lit;
        mcst_pkg::kind_t               lit_kind;
        logic                          lit_status;
    } plan_row_t;

    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [mcst_pkg::ACTION_W-1:0] s_action      = mcst_pkg::ACT_TICK;
    logic [mcst_pkg::IDX_W-1:0]    s_timer_index = '0;
    logic [mcst_pkg::PERIOD_W-1:0] s_period      = '0;
    logic                          s_repeat_req  = 1'b0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic [mcst_pkg::KIND_W-1:0]   m_kind;
    logic [mcst_pkg::IDX_W-1:0]    m_fired_index;
    logic                          m_status;
    logic                          m_last;

    logic [mcst_pkg::TIME_W-1:0]   now_ms;
    logic                          made_f  [mcst_pkg::NUM_TIMERS];
    logic                          live_f  [mcst_pkg::NUM_TIMERS];
    logic                          again_f [mcst_pkg::NUM_TIMERS];
    logic [mcst_pkg::PERIOD_W-1:0] per_tab [mcst_pkg::NUM_TIMERS];
    logic [mcst_pkg::TIME_W-1:0]   due_at  [mcst_pkg::NUM_TIMERS];

    reply_t timer_replies[$];
    reply_t step_out[$];
    reply_t head_reply;

    int mismatches = 0;
    int cycles     = 0;
    int sent       = 0;
    int stall_left = 0;

    plan_row_t plan [PLAN_LEN] = '{
        '{mcst_pkg::ACT_TICK,       4'd0,  24'd0,      1'b0, 1'b1, mcst_pkg::KIND_IDLE_TICK, 1'b0},
        '{mcst_pkg::ACT_START,      4'd3,  24'd0,      1'b0, 1'b1, mcst_pkg::KIND_CMD,       1'b1},
        '{mcst_pkg::ACT_STOP,       4'd0,  24'd0,      1'b1, 1'b1, mcst_pkg::KIND_CMD,       1'b1},
        '{mcst_pkg::ACT_SET_PERIOD, 4'd15, 24'd7,      1'b0, 1'b1, mcst_pkg::KIND_CMD,       1'b1},
        '{ACT_SPARE_5,              4'd9,  24'd0,      1'b0, 1'b1, mcst_pkg::KIND_CMD,       1'b0},
        '{ACT_SPARE_7,              4'd15, 24'hFFFFFF, 1'b1, 1'b1, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_CREATE,     4'd0,  24'd0,      1'b1, 1'b1, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_START,      4'd0,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_TICK,       4'd0,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_CREATE,     4'd15, 24'hFFFFFF, 1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_START,      4'd15, 24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_CREATE,     4'd1,  24'd1,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_START,      4'd1,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_CREATE,     4'd5,  24'd1,      1'b1, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_START,      4'd5,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_CREATE,     4'd2,  24'd2,      1'b1, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_START,      4'd2,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_TICK,       4'd7,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_TICK,       4'd0,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_STOP,       4'd2,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_STOP,       4'd2,  24'd0,      1'b0, 1'b1, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_CREATE,     4'd0,  24'd3,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_SET_PERIOD, 4'd5,  24'd2,      1'b1, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_TICK,       4'd0,  24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0},
        '{mcst_pkg::ACT_STOP,       4'd15, 24'd0,      1'b0, 1'b0, mcst_pkg::KIND_CMD,       1'b0}
    };

    multi_channel_software_timer_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_timer_index (s_timer_index),
        .s_period      (s_period),
        .s_repeat_req  (s_repeat_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_fired_index (m_fired_index),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    always #1 aclk = ~aclk;

    function automatic void timer_table_step(input logic [mcst_pkg::ACTION_W-1:0] act,
                                             input logic [mcst_pkg::IDX_W-1:0] slot,
                                             input logic [mcst_pkg::PERIOD_W-1:0] per,
                                             input logic rep);
        logic [mcst_pkg::TIME_W-1:0] diff;
        logic [mcst_pkg::TIME_W-1:0] key [mcst_pkg::NUM_TIMERS];
        logic                        due [mcst_pkg::NUM_TIMERS];
        int                          order [MAX_FIRES];
        int                          n;
        int                          best;
        bit                          found;
        logic                        st;
        step_out.delete();
        if (act == mcst_pkg::ACT_TICK) begin
            now_ms = now_ms + 1;
            for (int i = 0; i < mcst_pkg::NUM_TIMERS; i++) begin
                diff   = due_at[i] - now_ms;
                key[i] = diff ^ mcst_pkg::SIGN_FLIP;
                due[i] = live_f[i] && (diff == '0 || diff[mcst_pkg::TIME_W-1]);
            end
            n = 0;
            while (n < MAX_FIRES) begin
                found = 1'b0;
                best  = 0;
                for (int i = 0; i < mcst_pkg::NUM_TIMERS; i++) begin
                    if (due[i] && (!found || key[i] < key[best])) begin
                        best  = i;
                        found = 1'b1;
                    end
                end
                if (!found) break;
                due[best] = 1'b0;
                if (again_f[best]) due_at[best] = due_at[best] + {8'd0, per_tab[best]};
                else live_f[best] = 1'b0;
                order[n] = best;
                n++;
            end
            if (n == 0) begin
                step_out.push_back('{mcst_pkg::KIND_IDLE_TICK, 4'd0, 1'b0, 1'b1});
            end else begin
                for (int j = 0; j < n; j++)
                    step_out.push_back('{mcst_pkg::KIND_FIRED, 4'(order[j]), 1'b0, j == n - 1});
            end
        end else begin
            st = 1'b0;
            case (act)
                mcst_pkg::ACT_CREATE: begin
                    made_f[slot]  = 1'b1;
                    per_tab[slot] = per;
                    again_f[slot] = rep;
                    live_f[slot]  = 1'b0;
                    due_at[slot]  = '0;
                end
                mcst_pkg::ACT_START: begin
                    if (!made_f[slot]) st = 1'b1;
                    else begin
                        due_at[slot] = now_ms + {8'd0, per_tab[slot]};
                        live_f[slot] = 1'b1;
                    end
                end
                mcst_pkg::ACT_STOP: begin
                    if (!made_f[slot]) st = 1'b1;
                    else live_f[slot] = 1'b0;
                end
                mcst_pkg::ACT_SET_PERIOD: begin
                    if (!made_f[slot]) st = 1'b1;
                    else begin
                        per_tab[slot] = per;
                        due_at[slot]  = now_ms + {8'd0, per};
                        live_f[slot]  = 1'b1;
                    end
                end
                default: ;
            endcase
            step_out.push_back('{mcst_pkg::KIND_CMD, slot, st, 1'b1});
        end
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [mcst_pkg::ACTION_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return mcst_pkg::ACT_TICK;
        if (r < 55) return mcst_pkg::ACT_CREATE;
        if (r < 73) return mcst_pkg::ACT_START;
        if (r < 81) return mcst_pkg::ACT_STOP;
        if (r < 94) return mcst_pkg::ACT_SET_PERIOD;
        return mcst_pkg::ACTION_W'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
    endfunction

    function automatic logic [mcst_pkg::PERIOD_W-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return mcst_pkg::PERIOD_W'($urandom_range(0, 8));
        if (r < 85) return mcst_pkg::PERIOD_W'($urandom_range(9, 255));
        if (r < 95) return mcst_pkg::PERIOD_W'($urandom_range(0, 24'hFFFFFF));
        return 24'hFFFFFF;
    endfunction

    task automatic note_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", field, got, want, cycles);
        mismatches++;
    endtask

    task automatic send_request(input logic [mcst_pkg::ACTION_W-1:0] act,
                                input logic [mcst_pkg::IDX_W-1:0] slot,
                                input logic [mcst_pkg::PERIOD_W-1:0] per, input logic rep,
                                input logic lit, input mcst_pkg::kind_t lit_kind,
                                input logic lit_status);
        int gap;
        gap = pick_gap((sent / 32) % 3 == 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_timer_index <= slot;
        s_period      <= per;
        s_repeat_req  <= rep;
        do @(posedge aclk); while (!s_ready);
        timer_table_step(act, slot, per, rep);
        if (lit) begin
            timer_replies.push_back('{lit_kind, (lit_kind == mcst_pkg::KIND_CMD) ? slot : 4'd0,
                                      lit_status, 1'b1});
        end else begin
            foreach (step_out[j]) timer_replies.push_back(step_out[j]);
        end
        sent++;
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (timer_replies.size() != 0);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** multi_channel_software_timer_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ((cycles / 256) % 4 != 3 && $urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap(1'b0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (timer_replies.size() == 0) begin
                note_mismatch("reply with none pending, kind", m_kind, -1);
            end else begin
                head_reply = timer_replies.pop_front();
                if (m_kind !== head_reply.kind)
                    note_mismatch("kind", m_kind, head_reply.kind);
                if (m_fired_index !== head_reply.slot)
                    note_mismatch("fired_index", m_fired_index, head_reply.slot);
                if (m_status !== head_reply.status)
                    note_mismatch("status", m_status, head_reply.status);
                if (m_last !== head_reply.last)
                    note_mismatch("last", m_last, head_reply.last);
            end
        end
    end

    initial begin
        int  base;
        int  width;
        bit  burst_done;
        bit  mid_drained;
        logic [mcst_pkg::ACTION_W-1:0] act;
        now_ms      = '0;
        burst_done  = 1'b0;
        mid_drained = 1'b0;
        for (int i = 0; i < mcst_pkg::NUM_TIMERS; i++) begin
            made_f[i]  = 1'b0;
            live_f[i]  = 1'b0;
            again_f[i] = 1'b0;
            per_tab[i] = '0;
            due_at[i]  = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++)
            send_request(plan[r].act, plan[r].slot, plan[r].per, plan[r].rep,
                         plan[r].lit, plan[r].lit_kind, plan[r].lit_status);
        pause_until_drained();

        while (sent < PLAN_LEN + RANDOM_REQS) begin
            if (!mid_drained && sent >= PLAN_LEN + RANDOM_REQS / 2) begin
                pause_until_drained();
                mid_drained = 1'b1;
            end
            if ((!burst_done && sent >= PLAN_LEN + 30) || $urandom_range(0, 99) < 6) begin
                width = burst_done ? $urandom_range(3, mcst_pkg::NUM_TIMERS)
                                   : mcst_pkg::NUM_TIMERS;
                base  = $urandom_range(0, mcst_pkg::NUM_TIMERS - 1);
                for (int j = 0; j < width; j++)
                    send_request(mcst_pkg::ACT_CREATE,
                                 mcst_pkg::IDX_W'((base + j) % mcst_pkg::NUM_TIMERS),
                                 mcst_pkg::PERIOD_W'($urandom_range(0, 3)),
                                 (burst_done ? ($urandom_range(0, 3) != 0) : 1'b1),
                                 1'b0, mcst_pkg::KIND_CMD, 1'b0);
                for (int j = 0; j < width; j++)
                    send_request(mcst_pkg::ACT_START,
                                 mcst_pkg::IDX_W'((base + j) % mcst_pkg::NUM_TIMERS),
                                 pick_period(), 1'($urandom_range(0, 1)),
                                 1'b0, mcst_pkg::KIND_CMD, 1'b0);
                repeat ($urandom_range(2, 6))
                    send_request(mcst_pkg::ACT_TICK, mcst_pkg::IDX_W'($urandom_range(0, 15)),
                                 pick_period(), 1'($urandom_range(0, 1)),
                                 1'b0, mcst_pkg::KIND_CMD, 1'b0);
                burst_done = 1'b1;
            end else begin
                act = pick_action();
                send_request(act, mcst_pkg::IDX_W'($urandom_range(0, 15)), pick_period(),
                             1'($urandom_range(0, 1)), 1'b0, mcst_pkg::KIND_CMD, 1'b0);
            end
        end
        s_valid <= 1'b0;

        while (timer_replies.size() != 0) @(posedge aclk);
        repeat (2 * mcst_pkg::NUM_TIMERS + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** multi_channel_software_timer_unit: PASSED **");
        end else begin
            $display("** multi_channel_software_timer_unit: FAILED **");
        end
        $finish;
    end

endmodule
